@@ sv/ldsk_pkg.sv @@
`timescale 1ns / 1ps
package ldsk_pkg;

  localparam int POSE_ENTRIES = 64;
  localparam int PIDX_W       = $clog2(POSE_ENTRIES);
  localparam int CNT_W        = 7;
  localparam int PHASE_BITS   = 16;
  localparam int PERIOD_W     = 20;
  localparam int PROD_W       = PHASE_BITS + PERIOD_W;
  localparam int MAT_ELEMS    = 12;
  localparam int GRP          = 8;
  localparam int GRP_W        = $clog2(GRP);
  localparam int NGRP         = POSE_ENTRIES / GRP;

  localparam logic [1:0] OP_TIME  = 2'd0;
  localparam logic [1:0] OP_MAT   = 2'd1;
  localparam logic [1:0] OP_POINT = 2'd2;

  localparam logic [1:0] CFG_FRAME_PERIOD = 2'd0;
  localparam logic [1:0] CFG_HALF_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_POSE_COUNT   = 2'd2;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [PIDX_W-1:0]     pose_index;
    logic [3:0]            element_index;
    logic [31:0]           load_value;
    logic [30:0]           frame_start_us;
    logic [PHASE_BITS-1:0] phase;
    logic [31:0]           x;
    logic [31:0]           y;
    logic [31:0]           z;
    logic [31:0]           attributes;
  } in_item_t;

  typedef struct packed {
    logic              valid;
    in_item_t          item;
    logic [PIDX_W-1:0] sel;
    logic              beyond;
  } sel_item_t;

endpackage

@@ sv/lidar_point_deskew_top.sv @@
`timescale 1ns / 1ps
// lidar point deskew: per-point motion correction against a loaded pose table
// s_tdata carries one transaction: a pose time load, a matrix element load or a point
// pose times go to a flop table, matrix elements to twelve 64-entry memories
// each point gets time = frame start + phase * frame period / 2^16, the first
// pose at or after time minus half the pose spacing, and that pose's 3x4 transform
// when no pose qualifies the last valid pose is applied and beyond_table is set
// only points give an m_tdata transaction; loads leave the pipe silently
// throughput: one transaction per cycle while the output is not stalled, through the ten-stage pipeline
// stages: phase multiply, threshold add, table compare, two-level priority
// search, matrix memory read, nine multipliers, two adder levels, saturation
// stall: the whole pipe freezes while m_tvalid is high and m_tready is low;
// s_tready follows the same condition, so nothing is dropped or repeated
// reset: pipeline emptied, registers return to period 100000, half 5000, count 1;
// table contents are not cleared and must be loaded before use
// cfg writes land on the clock edge with cfg_we high; write only while idle
module lidar_point_deskew_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode, pose_index, element_index, load_value, frame_start_us, phase,
  // x_in, y_in, z_in, attributes_in
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // x_out, y_out, z_out, attributes_out, pose_used, beyond_table
  output logic [135:0] m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_data
);
  import ldsk_pkg::*;

  logic adv;
  logic [PERIOD_W-1:0] frame_period_us;
  logic [PERIOD_W-1:0] half_pose_period_us;
  logic [CNT_W-1:0] pose_count;
  in_item_t in_item;
  sel_item_t sel_item;
  logic [31:0] x_out, y_out, z_out, attributes_out;
  logic [PIDX_W-1:0] pose_used;
  logic beyond_table;

  // pipe moves unless a finished point waits at the output
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period_us     <= PERIOD_W'(100000);
      half_pose_period_us <= PERIOD_W'(5000);
      pose_count          <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_PERIOD: frame_period_us     <= cfg_data;
        CFG_HALF_PERIOD:  half_pose_period_us <= cfg_data;
        CFG_POSE_COUNT:   pose_count          <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack the input transaction
  assign in_item.opcode         = s_tdata[1:0];
  assign in_item.pose_index     = s_tdata[7:2];
  assign in_item.element_index  = s_tdata[11:8];
  assign in_item.load_value     = s_tdata[43:12];
  assign in_item.frame_start_us = s_tdata[74:44];
  assign in_item.phase          = s_tdata[90:75];
  assign in_item.x              = s_tdata[122:91];
  assign in_item.y              = s_tdata[154:123];
  assign in_item.z              = s_tdata[186:155];
  assign in_item.attributes     = s_tdata[218:187];

  ldsk_select u_select (
    .clk                 (clk),
    .rst                 (rst),
    .adv                 (adv),
    .in_valid            (s_tvalid),
    .in_item             (in_item),
    .frame_period_us     (frame_period_us),
    .half_pose_period_us (half_pose_period_us),
    .pose_count          (pose_count),
    .sel_out             (sel_item)
  );

  ldsk_transform u_transform (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .sel_in         (sel_item),
    .out_valid      (m_tvalid),
    .x_out          (x_out),
    .y_out          (y_out),
    .z_out          (z_out),
    .attributes_out (attributes_out),
    .pose_used      (pose_used),
    .beyond_table   (beyond_table)
  );

  assign m_tdata = {1'b0, beyond_table, pose_used, attributes_out, z_out, y_out, x_out};

endmodule

@@ sv/ldsk_select.sv @@
`timescale 1ns / 1ps
module ldsk_select (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  ldsk_pkg::in_item_t             in_item,
  input  logic [ldsk_pkg::PERIOD_W-1:0]  frame_period_us,
  input  logic [ldsk_pkg::PERIOD_W-1:0]  half_pose_period_us,
  input  logic [ldsk_pkg::CNT_W-1:0]     pose_count,
  output ldsk_pkg::sel_item_t            sel_out
);
  import ldsk_pkg::*;

  logic a_valid, b_valid, c_valid, d_valid, e_valid;
  in_item_t a_item, b_item, c_item, d_item, e_item;
  logic [PROD_W-1:0] b_prod;
  logic signed [32:0] c_thr;
  logic [31:0] time_tab [POSE_ENTRIES];
  logic [POSE_ENTRIES-1:0] hit;
  logic [POSE_ENTRIES-1:0] d_hit;
  logic [CNT_W-1:0] cnt_sat;
  logic [NGRP-1:0] grp_any, e_any;
  logic [GRP_W-1:0] grp_idx [NGRP];
  logic [GRP_W-1:0] e_idx [NGRP];
  logic [PIDX_W-1:0] sel_next;
  logic beyond_next;

  // valid chain and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      sel_out.valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      sel_out.valid  <= e_valid;
      sel_out.item   <= e_item;
      sel_out.sel    <= sel_next;
      sel_out.beyond <= beyond_next;
    end
  end

  // point time: phase times period, then start plus scaled phase minus half spacing
  always_ff @(posedge clk) begin
    if (adv) begin
      a_item <= in_item;
      b_item <= a_item;
      b_prod <= PROD_W'(a_item.phase) * PROD_W'(frame_period_us);
      c_item <= b_item;
      c_thr  <= $signed({2'b00, b_item.frame_start_us})
              + $signed(33'(b_prod[PROD_W-1:PHASE_BITS]))
              - $signed(33'(half_pose_period_us));
      d_item <= c_item;
      d_hit  <= hit;
      e_item <= d_item;
      e_any  <= grp_any;
      e_idx  <= grp_idx;
    end
  end

  // time table written in the compare stage so loads and points stay in order
  always_ff @(posedge clk) begin
    if (adv && c_valid && c_item.opcode == OP_TIME) begin
      time_tab[c_item.pose_index] <= c_item.load_value;
    end
  end

  always_comb begin
    if (pose_count == '0) begin
      cnt_sat = CNT_W'(1);
    end else if (pose_count > CNT_W'(POSE_ENTRIES)) begin
      cnt_sat = CNT_W'(POSE_ENTRIES);
    end else begin
      cnt_sat = pose_count;
    end
  end

  always_comb begin
    for (int i = 0; i < POSE_ENTRIES; i++) begin
      hit[i] = ($signed({time_tab[i][31], time_tab[i]}) >= c_thr) && (CNT_W'(i) < cnt_sat);
    end
  end

  // first hit inside each group of eight
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |d_hit[g*GRP +: GRP];
      grp_idx[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (d_hit[g*GRP + j]) grp_idx[g] = GRP_W'(j);
      end
    end
  end

  // first group with a hit
  always_comb begin
    sel_next    = PIDX_W'(cnt_sat - CNT_W'(1));
    beyond_next = 1'b1;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (e_any[g]) begin
        sel_next    = PIDX_W'(g * GRP) | PIDX_W'(e_idx[g]);
        beyond_next = 1'b0;
      end
    end
  end

endmodule

@@ sv/ldsk_transform.sv @@
`timescale 1ns / 1ps
module ldsk_transform (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  ldsk_pkg::sel_item_t          sel_in,
  output logic                         out_valid,
  output logic [31:0]                  x_out,
  output logic [31:0]                  y_out,
  output logic [31:0]                  z_out,
  output logic [31:0]                  attributes_out,
  output logic [ldsk_pkg::PIDX_W-1:0]  pose_used,
  output logic                         beyond_table
);
  import ldsk_pkg::*;

  logic g_valid, h_valid, i_valid;
  logic signed [31:0] g_m [MAT_ELEMS];
  logic signed [31:0] g_v [3];
  logic [31:0] g_attr, h_attr, i_attr;
  logic [PIDX_W-1:0] g_sel, h_sel, i_sel;
  logic g_beyond, h_beyond, i_beyond;
  logic signed [63:0] h_prod [3][3];
  logic signed [31:0] h_m3 [3];
  logic signed [65:0] i_sa [3];
  logic signed [65:0] i_sb [3];
  logic signed [66:0] sum [3];
  logic signed [50:0] q [3];
  logic [31:0] sat [3];
  logic mat_we;

  assign mat_we = adv && sel_in.valid && sel_in.item.opcode == OP_MAT
                  && sel_in.item.element_index < 4'(MAT_ELEMS);

  // one memory per matrix element, all read at the selected pose
  for (genvar k = 0; k < MAT_ELEMS; k++) begin : g_mem
    logic [31:0] mem [POSE_ENTRIES];
    always_ff @(posedge clk) begin
      if (mat_we && sel_in.item.element_index == 4'(k)) begin
        mem[sel_in.item.pose_index] <= sel_in.item.load_value;
      end
      if (adv) begin
        g_m[k] <= $signed(mem[sel_in.sel]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid   <= 1'b0;
      h_valid   <= 1'b0;
      i_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      g_valid   <= sel_in.valid && sel_in.item.opcode == OP_POINT;
      h_valid   <= g_valid;
      i_valid   <= h_valid;
      out_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_v[0]   <= $signed(sel_in.item.x);
      g_v[1]   <= $signed(sel_in.item.y);
      g_v[2]   <= $signed(sel_in.item.z);
      g_attr   <= sel_in.item.attributes;
      g_sel    <= sel_in.sel;
      g_beyond <= sel_in.beyond;
      h_attr   <= g_attr;
      h_sel    <= g_sel;
      h_beyond <= g_beyond;
      i_attr   <= h_attr;
      i_sel    <= h_sel;
      i_beyond <= h_beyond;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          h_prod[r][c] <= 64'(g_m[r*4+c]) * 64'(g_v[c]);
        end
        h_m3[r] <= g_m[r*4+3];
        // offset term carries the half-lsb rounding constant below bit 16
        i_sa[r] <= 66'(h_prod[r][0]) + 66'(h_prod[r][1]);
        i_sb[r] <= 66'(h_prod[r][2]) + 66'($signed({h_m3[r], 16'h8000}));
      end
      x_out          <= sat[0];
      y_out          <= sat[1];
      z_out          <= sat[2];
      attributes_out <= i_attr;
      pose_used      <= i_sel;
      beyond_table   <= i_beyond;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 67'(i_sa[r]) + 67'(i_sb[r]);
      q[r]   = 51'(sum[r] >>> 16);
      if (q[r] > 51'sd2147483647) begin
        sat[r] = 32'h7fff_ffff;
      end else if (q[r] < -51'sd2147483648) begin
        sat[r] = 32'h8000_0000;
      end else begin
        sat[r] = q[r][31:0];
      end
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import ldsk_pkg::*;

  // codes the package leaves out: the ignored opcode and the unused register slot
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;
  localparam int         LATENCY    = 10;
  localparam int         CYCLE_CAP  = 600000;
  localparam int         PHASE_ITEMS = 140;

  typedef struct {
    logic [1:0]  opcode;
    logic [5:0]  pose_index;
    logic [3:0]  element_index;
    logic [31:0] load_value;
    logic [30:0] frame_start_us;
    logic [15:0] phase;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] attributes;
  } point_item_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] attributes;
    logic [5:0]  pose_used;
    logic        beyond;
  } deskewed_t;

  typedef struct {
    point_item_t item;
    bit          typed;
    deskewed_t   result;
  } dir_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // opcode, pose_index, element_index, load_value, frame_start_us, phase,
  // x_in, y_in, z_in, attributes_in
  logic [223:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // x_out, y_out, z_out, attributes_out, pose_used, beyond_table
  logic [135:0] m_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [19:0]  cfg_data;

  // predictor copy of the pose table and the registers
  int          pose_times [POSE_ENTRIES];
  int          pose_mats  [POSE_ENTRIES][MAT_ELEMS];
  logic [19:0] frame_period;
  logic [19:0] half_period;
  logic [6:0]  pose_count;

  deskewed_t   pending_points [$];
  dir_row_t    dir_rows [$];
  int          errors;
  int          cycles;
  int          burst_left;
  int          stall_mode;
  int          time_base;
  int          time_step;

  lidar_point_deskew_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [223:0] pack_item(point_item_t it);
    return {5'd0, it.attributes, it.z, it.y, it.x, it.phase, it.frame_start_us,
            it.load_value, it.element_index, it.pose_index, it.opcode};
  endfunction

  // one output row: exact sum, round half up at bit 16, saturate
  function automatic logic [31:0] transform_row(int sel, int r, int vx, int vy, int vz);
    longint prod, whole, hi, lo, total;
    int     v [3];
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    hi = 0;
    lo = 0;
    for (int k = 0; k < 3; k++) begin
      prod  = longint'(pose_mats[sel][4*r+k]) * longint'(v[k]);
      whole = prod >>> 16;
      hi += whole;
      lo += prod - (whole <<< 16);
    end
    total = hi + longint'(pose_mats[sel][4*r+3]) + (lo + 32768) / 65536;
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    return total[31:0];
  endfunction

  function automatic deskewed_t deskew_point(point_item_t it);
    deskewed_t r;
    int        cnt;
    int        sel;
    bit        hit;
    longint    t;
    longint    thr;
    cnt = pose_count;
    if (cnt < 1) cnt = 1;
    if (cnt > POSE_ENTRIES) cnt = POSE_ENTRIES;
    t   = longint'(it.frame_start_us) + ((longint'(it.phase) * longint'(frame_period)) >> 16);
    thr = t - longint'(half_period);
    sel = cnt - 1;
    hit = 1'b0;
    for (int i = 0; i < cnt; i++) begin
      if (!hit && longint'(pose_times[i]) >= thr) begin
        sel = i;
        hit = 1'b1;
      end
    end
    r.x          = transform_row(sel, 0, it.x, it.y, it.z);
    r.y          = transform_row(sel, 1, it.x, it.y, it.z);
    r.z          = transform_row(sel, 2, it.x, it.y, it.z);
    r.attributes = it.attributes;
    r.pose_used  = sel[5:0];
    r.beyond     = ~hit;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_FRAME_PERIOD: frame_period = val;
      CFG_HALF_PERIOD:  half_period  = val;
      CFG_POSE_COUNT:   pose_count   = val[6:0];
      default: ;
    endcase
  endtask

  // one transaction on the input side; bursts with random gaps between them
  task automatic send_item(point_item_t it, bit typed, deskewed_t typed_result);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= pack_item(it);
    do @(posedge clk); while (!s_tready);
    case (it.opcode)
      OP_TIME:  pose_times[it.pose_index] = it.load_value;
      OP_MAT:   if (it.element_index < MAT_ELEMS)
                  pose_mats[it.pose_index][it.element_index] = it.load_value;
      OP_POINT: pending_points.push_back(typed ? typed_result : deskew_point(it));
      default: ;
    endcase
  endtask

  // hold the sender until every point has come back, then let the pipe empty
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic point_item_t blank_item(logic [1:0] op);
    point_item_t it;
    it = '{default: '0};
    it.opcode = op;
    return it;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 11))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      4, 5, 6: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_matrix_value(int e);
    if ($urandom_range(0, 4) < 3) begin
      if (e % 4 == 3) return $urandom_range(0, 32'h1fffffff) - 32'h10000000;
      return $urandom_range(0, 32'h40000) - 32'h20000;
    end
    return $urandom;
  endfunction

  function automatic point_item_t random_point();
    point_item_t it;
    longint      span;
    it = blank_item(OP_POINT);
    span = longint'(time_step) * POSE_ENTRIES + 2 * longint'(half_period) + 2;
    if ($urandom_range(0, 4) == 0)
      it.frame_start_us = $urandom;
    else
      it.frame_start_us = time_base + $urandom_range(0, span > 32'h7fff0000 ? 32'h7fff0000 : span)
                          - longint'(frame_period) / 2;
    it.phase      = $urandom_range(0, 65535);
    it.x          = pick_coord();
    it.y          = pick_coord();
    it.z          = pick_coord();
    it.attributes = $urandom;
    return it;
  endfunction

  // every entry gets a non-decreasing time and a full matrix
  task automatic load_table;
    point_item_t it;
    deskewed_t   none;
    none = '{default: '0};
    time_base = $urandom_range(0, 100000000);
    time_step = $urandom_range(0, 200000);
    for (int p = 0; p < POSE_ENTRIES; p++) begin
      it = blank_item(OP_TIME);
      it.pose_index = p;
      it.load_value = time_base + p * time_step;
      send_item(it, 1'b0, none);
      for (int e = 0; e < MAT_ELEMS; e++) begin
        it = blank_item(OP_MAT);
        it.pose_index    = p;
        it.element_index = e;
        it.load_value    = pick_matrix_value(e);
        send_item(it, 1'b0, none);
      end
    end
  endtask

  task automatic random_items(int n);
    point_item_t it;
    deskewed_t   none;
    int          roll;
    none = '{default: '0};
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        it = random_point();
      end else if (roll < 80) begin
        // retime one entry, mostly near its slot, sometimes anywhere
        it = blank_item(OP_TIME);
        it.pose_index = $urandom_range(0, POSE_ENTRIES - 1);
        it.load_value = ($urandom_range(0, 9) == 0) ? $urandom :
                        time_base + it.pose_index * time_step + $urandom_range(0, 2000) - 1000;
      end else if (roll < 92) begin
        it = blank_item(OP_MAT);
        it.pose_index    = $urandom_range(0, POSE_ENTRIES - 1);
        it.element_index = $urandom_range(0, MAT_ELEMS - 1);
        it.load_value    = pick_matrix_value(it.element_index);
      end else begin
        // noise: ignored opcode or a matrix slot past the end, random content
        it = random_point();
        it.opcode        = (roll < 96) ? OP_IGNORED : OP_MAT;
        it.pose_index    = $urandom;
        it.element_index = $urandom_range(MAT_ELEMS, 15);
        it.load_value    = $urandom;
      end
      send_item(it, 1'b0, none);
    end
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // receiver stalls on its own pattern, with stretches of steady ready
  always @(posedge clk) begin
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 2);
    m_tready <= (stall_mode == 0) ? 1'b1 :
                (stall_mode == 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
  end

  // compare each output transaction with the oldest pending point
  always @(posedge clk) begin
    deskewed_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected transaction", m_tdata[31:0], 32'h0);
      end else begin
        want = pending_points.pop_front();
        if (m_tdata[31:0]    !== want.x)          report_mismatch("x_out", m_tdata[31:0], want.x);
        if (m_tdata[63:32]   !== want.y)          report_mismatch("y_out", m_tdata[63:32], want.y);
        if (m_tdata[95:64]   !== want.z)          report_mismatch("z_out", m_tdata[95:64], want.z);
        if (m_tdata[127:96]  !== want.attributes)
          report_mismatch("attributes_out", m_tdata[127:96], want.attributes);
        if (m_tdata[133:128] !== want.pose_used)
          report_mismatch("pose_used", 32'(m_tdata[133:128]), 32'(want.pose_used));
        if (m_tdata[134]     !== want.beyond)
          report_mismatch("beyond_table", 32'(m_tdata[134]), 32'(want.beyond));
      end
    end
  end

  initial begin
    point_item_t it;
    deskewed_t   res;
    dir_row_t    row;
    logic [19:0] periods [6];
    logic [19:0] halves  [6];
    logic [6:0]  counts  [6];
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    errors       = 0;
    cycles       = 0;
    burst_left   = 0;
    stall_mode   = 0;
    frame_period = 20'd100000;
    half_period  = 20'd5000;
    pose_count   = 7'd1;
    foreach (pose_times[i]) pose_times[i] = 0;
    foreach (pose_mats[i, j]) pose_mats[i][j] = 0;

    // directed rows: entry 0 at 1000 us, identity transform, reset registers
    row = '{default: '0};
    row.item = blank_item(OP_TIME);
    row.item.load_value = 1000;
    dir_rows.push_back(row);
    for (int e = 0; e < MAT_ELEMS; e++) begin
      row = '{default: '0};
      row.item = blank_item(OP_MAT);
      row.item.element_index = e;
      row.item.load_value = (e == 0 || e == 5 || e == 10) ? 32'h10000 : 32'h0;
      dir_rows.push_back(row);
    end
    // extreme coordinates pass an identity unchanged
    row = '{default: '0};
    row.item = blank_item(OP_POINT);
    row.item.x = 32'h7fffffff;
    row.item.y = 32'h80000000;
    row.item.attributes = 32'hffffffff;
    row.typed = 1'b1;
    row.result = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 6'd0, 1'b0};
    dir_rows.push_back(row);
    // latest point time: no pose qualifies, last valid one is applied
    row = '{default: '0};
    row.item = blank_item(OP_POINT);
    row.item.y = 32'h7fffffff;
    row.item.z = 32'h80000000;
    row.item.frame_start_us = 31'h7fffffff;
    row.item.phase = 16'hffff;
    row.typed = 1'b1;
    row.result = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h0, 6'd0, 1'b1};
    dir_rows.push_back(row);
    // ignored opcode with every bit set
    row = '{default: '0};
    row.item = '{default: '1};
    row.item.opcode = OP_IGNORED;
    dir_rows.push_back(row);
    // matrix element past the end, and a time load to the top entry
    row = '{default: '0};
    row.item = blank_item(OP_MAT);
    row.item.element_index = 4'hf;
    row.item.load_value = 32'hffffffff;
    dir_rows.push_back(row);
    row = '{default: '0};
    row.item = blank_item(OP_TIME);
    row.item.pose_index = 6'd63;
    row.item.load_value = 32'h80000000;
    dir_rows.push_back(row);
    // threshold exactly on the pose time, then one past it
    row = '{default: '0};
    row.item = blank_item(OP_POINT);
    row.item.frame_start_us = 6000;
    row.item.x = 32'h12345678;
    row.item.y = 32'hfedcba98;
    row.item.z = 32'h00010000;
    row.item.attributes = 32'h5a5a5a5a;
    row.typed = 1'b1;
    row.result = '{32'h12345678, 32'hfedcba98, 32'h00010000, 32'h5a5a5a5a, 6'd0, 1'b0};
    dir_rows.push_back(row);
    row.item.frame_start_us = 6001;
    row.result.beyond = 1'b1;
    dir_rows.push_back(row);
    // largest translation drives x into positive saturation
    row = '{default: '0};
    row.item = blank_item(OP_MAT);
    row.item.element_index = 4'd3;
    row.item.load_value = 32'h7fffffff;
    dir_rows.push_back(row);
    row = '{default: '0};
    row.item = blank_item(OP_POINT);
    row.item.x = 32'h7fffffff;
    row.item.y = 32'h1;
    row.item.z = 32'hffffffff;
    row.item.attributes = 32'h1;
    row.typed = 1'b1;
    row.result = '{32'h7fffffff, 32'h1, 32'hffffffff, 32'h1, 6'd0, 1'b0};
    dir_rows.push_back(row);
    // mid-sweep phase, left to the predictor
    row = '{default: '0};
    row.item = blank_item(OP_POINT);
    row.item.phase = 16'h8000;
    row.item.x = 32'hffff0000;
    dir_rows.push_back(row);

    // setting per phase: extremes, zero period, count saturation both ways
    periods = '{20'd100000, 20'd1, 20'd0, 20'hfffff, 20'd1000000, 20'd33333};
    halves  = '{20'd5000, 20'd0, 20'hfffff, 20'd1000000, 20'd1, 20'd70000};
    counts  = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd37, 7'd64};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
    drain();

    load_table();
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CFG_FRAME_PERIOD, periods[ph]);
      write_reg(CFG_HALF_PERIOD, halves[ph]);
      write_reg(CFG_POSE_COUNT, {13'd0, counts[ph]});
      if (ph == 2) write_reg(CFG_SPARE, 20'hfffff);
      random_items(PHASE_ITEMS);
    end

    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ldsk_pkg.sv
sv/ldsk_select.sv
sv/ldsk_transform.sv
sv/lidar_point_deskew_top.sv
test/testbench.sv
